// ===== hdl/sid_pkg.sv =====
// Shared types and constants for the signed integer divider.
// Holds the word width, queue depth default and the classified operand record.
// No dependencies.
package sid_pkg;

   localparam int WORD_W          = 32;
   localparam int STAGES          = WORD_W;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [WORD_W-1:0] INT_MAX_C = {1'b0, {(WORD_W-1){1'b1}}};

   // Operand pair after classification: magnitudes, result sign, zero divisor.
   typedef struct packed {
      logic [WORD_W-1:0] mag_a;
      logic [WORD_W-1:0] mag_b;
      logic              neg;
      logic              dz;
   } sid_item_type;

   function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
      magnitude = v[WORD_W-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

// ===== hdl/sid_front.sv =====
// Front end of the divider: takes requests and classifies them.
// Registers magnitudes, result sign and zero-divisor flag. Uses sid_pkg.
module sid_front
   import sid_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [WORD_W-1:0] req_dividend,
   input  logic signed [WORD_W-1:0] req_divisor,
   output logic                     item_valid,
   input  logic                     item_ready,
   output sid_item_type             item
);

   logic         valid_ff, valid_in;
   sid_item_type item_ff, item_in;
   logic         take;

   assign req_ready = !valid_ff || item_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      item_in       = item_ff;
      item_in.mag_a = magnitude(req_dividend);
      item_in.mag_b = magnitude(req_divisor);
      item_in.neg   = req_dividend[WORD_W-1] ^ req_divisor[WORD_W-1];
      item_in.dz    = (req_divisor == '0);
      valid_in      = take || (valid_ff && !item_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hdl/sid_queue.sv =====
// Short queue between the front end and the divider pipeline.
// Holds classified operand records so each side can stall on its own. Uses sid_pkg.
module sid_queue
   import sid_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  sid_item_type push_item,
   output logic         pop_valid,
   input  logic         pop_ready,
   output sid_item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   sid_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTH
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count exceeds depth");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count missed a push");

   a_count_drains: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count missed a pop");
`endif

endmodule

// ===== hdl/sid_back.sv =====
// Back end of the divider: restoring shift-subtract pipeline, one quotient
// bit per stage, then sign fix and special cases into the result register. Uses sid_pkg.
module sid_back
   import sid_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   output logic                     item_ready,
   input  sid_item_type             item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [WORD_W-1:0] rsp_quotient,
   output logic                     rsp_overflow,
   output logic                     rsp_divide_by_zero
);

   // Stage 0 holds the loaded operands; stage i holds i quotient bits.
   logic              vld_ff [STAGES+1];
   logic [WORD_W-1:0] rem_ff [STAGES+1];
   logic [WORD_W-1:0] num_ff [STAGES+1];
   logic [WORD_W-1:0] den_ff [STAGES+1];
   logic              neg_ff [STAGES+1];
   logic              dz_ff  [STAGES+1];

   logic              vld_in [STAGES+1];
   logic [WORD_W-1:0] rem_in [STAGES+1];
   logic [WORD_W-1:0] num_in [STAGES+1];
   logic [WORD_W-1:0] den_in [STAGES+1];
   logic              neg_in [STAGES+1];
   logic              dz_in  [STAGES+1];

   logic [WORD_W:0]   rem_sh [STAGES];
   logic [WORD_W:0]   rem_sub [STAGES];
   logic              ge     [STAGES];

   logic              out_valid_ff, out_valid_in;
   logic [WORD_W-1:0] quot_ff, quot_in;
   logic              ovf_ff, ovf_in;
   logic              dbz_ff, dbz_in;
   logic              advance;
   logic [WORD_W-1:0] qmag;

   // Whole pipeline moves together whenever the result register can take data.
   assign advance    = !out_valid_ff || rsp_ready;
   assign item_ready = advance;

   always_comb begin
      vld_in[0] = item_valid;
      rem_in[0] = '0;
      num_in[0] = item.mag_a;
      den_in[0] = item.mag_b;
      neg_in[0] = item.neg;
      dz_in[0]  = item.dz;
      for (int i = 0; i < STAGES; i++) begin
         rem_sh[i]  = {rem_ff[i], num_ff[i][WORD_W-1]};
         ge[i]      = (rem_sh[i] >= {1'b0, den_ff[i]});
         rem_sub[i] = rem_sh[i] - {1'b0, den_ff[i]};
         // Remainder stays below the divisor, so it fits the word.
         rem_in[i+1] = ge[i] ? rem_sub[i][WORD_W-1:0] : rem_sh[i][WORD_W-1:0];
         num_in[i+1] = {num_ff[i][WORD_W-2:0], ge[i]};
         den_in[i+1] = den_ff[i];
         neg_in[i+1] = neg_ff[i];
         dz_in[i+1]  = dz_ff[i];
         vld_in[i+1] = vld_ff[i];
      end
   end

   always_comb begin
      qmag   = num_ff[STAGES];
      ovf_in = 1'b0;
      dbz_in = dz_ff[STAGES];
      if (dz_ff[STAGES]) begin
         quot_in = '0;
      end else if (neg_ff[STAGES]) begin
         quot_in = ~qmag + 1'b1;
      end else if (qmag[WORD_W-1]) begin
         // Minimum over minus one: saturate.
         quot_in = INT_MAX_C;
         ovf_in  = 1'b1;
      end else begin
         quot_in = qmag;
      end
      out_valid_in = advance ? vld_ff[STAGES] : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= STAGES; i++) begin
            vld_ff[i] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            for (int i = 0; i <= STAGES; i++) begin
               vld_ff[i] <= vld_in[i];
            end
         end
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         for (int i = 0; i <= STAGES; i++) begin
            rem_ff[i] <= rem_in[i];
            num_ff[i] <= num_in[i];
            den_ff[i] <= den_in[i];
            neg_ff[i] <= neg_in[i];
            dz_ff[i]  <= dz_in[i];
         end
         quot_ff <= quot_in;
         ovf_ff  <= ovf_in;
         dbz_ff  <= dbz_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_quotient       = quot_ff;
   assign rsp_overflow       = ovf_ff;
   assign rsp_divide_by_zero = dbz_ff;

`ifndef SYNTH
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(ovf_ff && dbz_ff))
      else $error("overflow and divide-by-zero both set");

   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && ovf_ff |-> quot_ff == INT_MAX_C)
      else $error("overflow without saturated quotient");

   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && dbz_ff |-> quot_ff == '0)
      else $error("divide by zero with nonzero quotient");

   a_stall_holds_tail: assert property (@(posedge clock) disable iff (reset)
      !advance |=> vld_ff[STAGES] == $past(vld_ff[STAGES]))
      else $error("pipeline tail moved during stall");
`endif

endmodule

// ===== hdl/signed_integer_divider.sv =====
// Signed 32-bit divider, quotient truncated toward zero, with overflow and
// divide-by-zero flags. A request passes the front register, the queue, 33
// pipeline registers of the shift-subtract array (one quotient bit per stage)
// and the result register on its way to the response.
// Throughput is one request per cycle while the response side keeps up.
// Synchronous reset empties the front register, queue and pipeline.
module signed_integer_divider
   import sid_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [WORD_W-1:0] req_dividend,
   input  logic signed [WORD_W-1:0] req_divisor,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [WORD_W-1:0] rsp_quotient,
   output logic                     rsp_overflow,
   output logic                     rsp_divide_by_zero
);

   logic         fr_valid, fr_ready;
   sid_item_type fr_item;
   logic         bk_valid, bk_ready;
   sid_item_type bk_item;

   sid_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_dividend (req_dividend),
      .req_divisor  (req_divisor),
      .item_valid   (fr_valid),
      .item_ready   (fr_ready),
      .item         (fr_item)
   );

   sid_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_item  (fr_item),
      .pop_valid  (bk_valid),
      .pop_ready  (bk_ready),
      .pop_item   (bk_item)
   );

   sid_back u_back (
      .clock              (clock),
      .reset              (reset),
      .item_valid         (bk_valid),
      .item_ready         (bk_ready),
      .item               (bk_item),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_quotient       (rsp_quotient),
      .rsp_overflow       (rsp_overflow),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

endmodule

// ===== verif/tb_signed_integer_divider.sv =====
// Self-checking testbench for signed_integer_divider: random and corner-case requests,
// checked against a truncating signed-division predictor held in the bench.
// Depends on sid_pkg and the signed_integer_divider RTL.
module tb_signed_integer_divider
   import sid_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 600;

   typedef struct {
      logic signed [WORD_W-1:0] dividend;
      logic signed [WORD_W-1:0] divisor;
   } operand_pair_type;

   typedef struct {
      logic signed [WORD_W-1:0] dividend;
      logic signed [WORD_W-1:0] divisor;
      logic signed [WORD_W-1:0] quotient;
      logic                     overflow;
      logic                     divide_by_zero;
   } quotient_rec_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [WORD_W-1:0] req_dividend = '0;
   logic signed [WORD_W-1:0] req_divisor = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [WORD_W-1:0] rsp_quotient;
   logic                     rsp_overflow;
   logic                     rsp_divide_by_zero;

   operand_pair_type pending_pairs[$];
   quotient_rec_type expected_quotients[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned error_count = 0;
   int unsigned checked_count = 0;
   int unsigned zero_div_count = 0;
   int unsigned overflow_count = 0;
   int unsigned stall_cycles = 0;

   localparam logic signed [WORD_W-1:0] INT_MIN_C = {1'b1, {(WORD_W-1){1'b0}}};

   signed_integer_divider dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_quotient       (rsp_quotient),
      .rsp_overflow       (rsp_overflow),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always #4 clock = ~clock;

   // Shift-subtract on the magnitudes, then apply the sign; saturate the one
   // positive quotient that does not fit.
   function automatic quotient_rec_type divide_truncated(logic signed [WORD_W-1:0] a,
                                                         logic signed [WORD_W-1:0] b);
      quotient_rec_type  r;
      logic [WORD_W-1:0] mag_num;
      logic [WORD_W-1:0] mag_den;
      logic [WORD_W-1:0] qmag;
      logic [WORD_W:0]   partial;
      logic              negate;
      r.dividend       = a;
      r.divisor        = b;
      r.quotient       = '0;
      r.overflow       = 1'b0;
      r.divide_by_zero = 1'b0;
      if (b == 0) begin
         r.divide_by_zero = 1'b1;
         return r;
      end
      mag_num = a[WORD_W-1] ? WORD_W'(0) - a : a;
      mag_den = b[WORD_W-1] ? WORD_W'(0) - b : b;
      negate  = a[WORD_W-1] ^ b[WORD_W-1];
      qmag    = '0;
      partial = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         partial = {partial[WORD_W-1:0], mag_num[i]};
         if (partial >= {1'b0, mag_den}) begin
            partial = partial - {1'b0, mag_den};
            qmag[i] = 1'b1;
         end
      end
      if (negate) begin
         r.quotient = WORD_W'(0) - qmag;
      end else if (qmag > INT_MAX_C) begin
         r.quotient = INT_MAX_C;
         r.overflow = 1'b1;
      end else begin
         r.quotient = qmag;
      end
      return r;
   endfunction

   function automatic logic signed [WORD_W-1:0] corner_value();
      case ($urandom_range(6))
         0:       return INT_MIN_C;
         1:       return INT_MAX_C;
         2:       return -1;
         3:       return 0;
         4:       return 1;
         5:       return INT_MIN_C + 1;
         default: return -2;
      endcase
   endfunction

   task automatic push_pair(logic signed [WORD_W-1:0] a, logic signed [WORD_W-1:0] b);
      operand_pair_type p;
      p.dividend = a;
      p.divisor  = b;
      pending_pairs.push_back(p);
   endtask

   task automatic queue_random_pairs(int unsigned count);
      logic signed [WORD_W-1:0] a;
      logic signed [WORD_W-1:0] b;
      for (int unsigned n = 0; n < count; n++) begin
         a = $urandom;
         b = $urandom;
         case ($urandom_range(9))
            4: begin
               a = int'($urandom_range(128)) - 64;
               b = int'($urandom_range(32)) - 16;
            end
            5: b = int'($urandom_range(512)) - 256;
            6: begin
               // divisor near the dividend shifted down, so quotients land near 2^k
               b = (a >>> $urandom_range(WORD_W - 2)) + int'($urandom_range(2)) - 1;
               if ($urandom_range(1)) b = -b;
            end
            7: begin
               if ($urandom_range(1)) a = corner_value();
               else b = corner_value();
            end
            8: begin
               a = corner_value();
               b = corner_value();
            end
            9: begin
               a = INT_MIN_C;
               if ($urandom_range(1)) b = int'($urandom_range(64)) - 32;
            end
            default: ;
         endcase
         push_pair(a, b);
      end
   endtask

   task automatic wait_results_drained();
      while (pending_pairs.size() != 0 || req_valid) @(posedge clock);
      while (expected_quotients.size() != 0) @(posedge clock);
   endtask

   // Driver: hold the request until accepted, then advance or idle.
   always @(posedge clock) begin
      operand_pair_type p;
      quotient_rec_type e;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            e = divide_truncated(req_dividend, req_divisor);
            expected_quotients.push_back(e);
            if (e.divide_by_zero) zero_div_count++;
            if (e.overflow) overflow_count++;
         end
         if (!req_valid || req_ready) begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               p = pending_pairs.pop_front();
               req_valid    <= 1'b1;
               req_dividend <= p.dividend;
               req_divisor  <= p.divisor;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted response with the oldest expected quotient.
   always @(posedge clock) begin
      quotient_rec_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_quotients.size() == 0) begin
               error_count++;
               $display("%0t: response with no request outstanding: quotient %0d", $time,
                        rsp_quotient);
            end else begin
               e = expected_quotients.pop_front();
               checked_count++;
               if (rsp_quotient !== e.quotient) begin
                  error_count++;
                  $display("%0t: %0d / %0d quotient expected %0d actual %0d", $time,
                           e.dividend, e.divisor, e.quotient, rsp_quotient);
               end
               if (rsp_overflow !== e.overflow) begin
                  error_count++;
                  $display("%0t: %0d / %0d overflow expected %0b actual %0b", $time,
                           e.dividend, e.divisor, e.overflow, rsp_overflow);
               end
               if (rsp_divide_by_zero !== e.divide_by_zero) begin
                  error_count++;
                  $display("%0t: %0d / %0d divide_by_zero expected %0b actual %0b", $time,
                           e.dividend, e.divisor, e.divide_by_zero, rsp_divide_by_zero);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: no progress on either channel for too long ends the run.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("signed_integer_divider test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      send_idle_pct = 19;
      recv_idle_pct = 86;
      // corner cases: extremes, minimum operands, minus one, zero divisor
      push_pair(INT_MIN_C, INT_MIN_C);
      push_pair(5, INT_MIN_C);
      push_pair(-5, INT_MIN_C);
      push_pair(INT_MIN_C, -1);
      push_pair(INT_MIN_C, 1);
      push_pair(INT_MIN_C, 2);
      push_pair(INT_MIN_C, -3);
      push_pair(INT_MIN_C, 7);
      push_pair(INT_MIN_C, INT_MAX_C);
      push_pair(INT_MAX_C, -1);
      push_pair(INT_MAX_C, 1);
      push_pair(INT_MAX_C, INT_MAX_C);
      push_pair(INT_MAX_C, INT_MIN_C);
      push_pair(0, 0);
      push_pair(7, 0);
      push_pair(INT_MIN_C, 0);
      push_pair(INT_MAX_C, 0);
      push_pair(-7, 2);
      push_pair(7, -2);
      push_pair(-7, -2);
      push_pair(0, 5);
      push_pair(1, INT_MAX_C);
      push_pair(-1, INT_MIN_C + 1);
      push_pair(32'shAAAA_AAAA, 32'sh5555_5555);
      queue_random_pairs(RANDOM_ITEMS);
      wait_results_drained();

      @(negedge clock);
      send_idle_pct = 86;
      recv_idle_pct = 19;
      queue_random_pairs(RANDOM_ITEMS);
      wait_results_drained();

      @(negedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_pairs(RANDOM_ITEMS - 24);
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      error_count += expected_quotients.size();
      $display("Checked %0d quotients across three idle mixes, %0d divide-by-zero, %0d overflow.",
               checked_count, zero_div_count, overflow_count);
      $display("Mismatches: %0d", error_count);
      if (error_count == 0) begin
         $display("signed_integer_divider test passed");
      end else begin
         $display("signed_integer_divider test failed");
      end
      $finish;
   end

endmodule
